// ===== src/cses_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cses_pkg;

  localparam int PAYLOAD_BYTES = 8;
  localparam int DATA_W        = 8 * PAYLOAD_BYTES;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;
  localparam int PP_W          = 65;
  localparam int PROD_W        = 98;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIG_START     = 3'd0,
    REG_BIT_LENGTH    = 3'd1,
    REG_LITTLE_ENDIAN = 3'd2,
    REG_SIGNED_EN     = 3'd3,
    REG_SCALE_FACTOR  = 3'd4,
    REG_SCALE_OFFSET  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]         sig_start;
    logic [6:0]         bit_length;
    logic               little_endian;
    logic               signed_en;
    logic signed [31:0] scale_factor;
    logic signed [47:0] scale_offset;
  } cfg_t;

  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  payload_length;
  } in_t;

  typedef struct packed {
    logic [63:0] raw;
    logic        neg;
    logic        in_range;
  } ext_t;

  typedef struct packed {
    logic signed [63:0] raw_bits;
    logic signed [63:0] physical_value;
    logic               in_range;
  } out_t;

endpackage

`default_nettype wire

// ===== src/cses_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cses_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [cses_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cses_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  output cses_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sig_start     <= 6'd0;
      cfg.bit_length    <= 7'd8;
      cfg.little_endian <= 1'b1;
      cfg.signed_en     <= 1'b0;
      cfg.scale_factor  <= 32'sd65536;
      cfg.scale_offset  <= 48'sd0;
    end else if (cfg_wr_en) begin
      unique case (cses_pkg::reg_idx_t'(cfg_index))
        cses_pkg::REG_SIG_START:     cfg.sig_start     <= cfg_wr_data[5:0];
        cses_pkg::REG_BIT_LENGTH:    cfg.bit_length    <= cfg_wr_data[6:0];
        cses_pkg::REG_LITTLE_ENDIAN: cfg.little_endian <= cfg_wr_data[0];
        cses_pkg::REG_SIGNED_EN:     cfg.signed_en     <= cfg_wr_data[0];
        cses_pkg::REG_SCALE_FACTOR:  cfg.scale_factor  <= $signed(cfg_wr_data[31:0]);
        cses_pkg::REG_SCALE_OFFSET:  cfg.scale_offset  <= $signed(cfg_wr_data[47:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cses_extract.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cses_extract (
  input  logic             clk,
  input  logic             rst,
  input  cses_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  cses_pkg::in_t    in_data,
  output logic             ext_valid,
  input  logic             ext_stall,
  output cses_pkg::ext_t   ext_data
);

  function automatic logic [63:0] low_mask(input logic [6:0] bits);
    logic [63:0] m;
    m = bits[6] ? {64{1'b1}} : ((64'd1 << bits[5:0]) - 64'd1);
    return m;
  endfunction

  logic [6:0]      len;
  logic [6:0]      len_m1;
  logic [3:0]      avail;
  logic [6:0]      msb_le;
  logic [3:0]      hi_byte;
  logic [6:0]      flip_sb;
  logic [6:0]      q;
  logic [6:0]      lim;
  logic [6:0]      e;
  logic [6:0]      n;
  logic [63:0]     swapped;
  logic [63:0]     src;
  logic [63:0]     shifted;
  logic [63:0]     field;
  logic [5:0]      sh;
  logic [6:0]      cnt;
  logic            hit;
  logic            sgn;
  logic            en;
  cses_pkg::ext_t  ext_next;

  always_comb begin
    len = (cfg.bit_length == 7'd0) ? 7'd1 :
          (cfg.bit_length > 7'd64) ? 7'd64 : cfg.bit_length;
    len_m1 = len - 7'd1;
    avail = (in_data.payload_length > 4'(cses_pkg::PAYLOAD_BYTES)) ?
            4'(cses_pkg::PAYLOAD_BYTES) : in_data.payload_length;

    msb_le  = {1'b0, cfg.sig_start} + len_m1;
    flip_sb = {1'b0, cfg.sig_start[5:3], ~cfg.sig_start[2:0]};
    q       = flip_sb + len_m1;
    hi_byte = cfg.little_endian ? msb_le[6:3] : {1'b0, cfg.sig_start[5:3]};
    hit = (hi_byte < avail);

    // Motorola: last gathered bit stops at the end of the valid bytes
    lim = {avail[3:0], 3'b000} - 7'd1;
    e   = (q < lim) ? q : lim;
    n   = e - flip_sb + 7'd1;

    for (int k = 0; k < cses_pkg::PAYLOAD_BYTES; k++) begin
      swapped[8*k +: 8] = in_data.payload[8*(cses_pkg::PAYLOAD_BYTES-1-k) +: 8];
    end

    src = cfg.little_endian ? in_data.payload : swapped;
    sh  = cfg.little_endian ? cfg.sig_start : ~e[5:0];
    cnt = cfg.little_endian ? len : n;

    shifted = src >> sh;
    field   = hit ? (shifted & low_mask(cnt)) : 64'd0;
    sgn     = cfg.signed_en & field[len_m1[5:0]];

    ext_next.raw      = sgn ? (field | ~low_mask(len)) : field;
    ext_next.neg      = sgn;
    ext_next.in_range = hit;
  end

  assign en       = !ext_valid || !ext_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_valid <= 1'b0;
    end else if (en) begin
      ext_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ext_data <= ext_next;
    end
  end

`ifndef SYNTHESIS
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (ext_valid && !ext_data.in_range) |-> (ext_data.raw == 64'd0 && !ext_data.neg))
    else $error("out-of-range signal left a nonzero raw value");
`endif

endmodule

`default_nettype wire

// ===== src/cses_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cses_scale (
  input  logic             clk,
  input  logic             rst,
  input  cses_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  cses_pkg::ext_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cses_pkg::out_t   out_data
);

  logic signed [32:0]                     a_lo;
  logic signed [32:0]                     a_hi;
  logic signed [cses_pkg::PP_W-1:0]       pp_lo_next;
  logic signed [cses_pkg::PP_W-1:0]       pp_hi_next;
  logic signed [cses_pkg::PROD_W-1:0]     prod_next;
  logic signed [cses_pkg::PROD_W-1:0]     total;
  logic                                   fits;
  cses_pkg::out_t                         out_next;

  logic                                   mul_valid;
  logic signed [cses_pkg::PP_W-1:0]       pp_lo;
  logic signed [cses_pkg::PP_W-1:0]       pp_hi;
  logic [63:0]                            mul_raw;
  logic                                   mul_inr;

  logic                                   sum_valid;
  logic signed [cses_pkg::PROD_W-1:0]     prod;
  logic [63:0]                            sum_raw;
  logic                                   sum_inr;

  logic                                   en_m;
  logic                                   en_s;
  logic                                   en_o;

  always_comb begin
    a_lo = $signed({1'b0, in_data.raw[31:0]});
    a_hi = $signed({in_data.neg, in_data.raw[63:32]});
    pp_lo_next = cses_pkg::PP_W'(a_lo) * cses_pkg::PP_W'(cfg.scale_factor);
    pp_hi_next = cses_pkg::PP_W'(a_hi) * cses_pkg::PP_W'(cfg.scale_factor);

    prod_next = cses_pkg::PROD_W'(pp_lo) + (cses_pkg::PROD_W'(pp_hi) <<< 32);

    total = prod + cses_pkg::PROD_W'(cfg.scale_offset);
    fits  = (total[cses_pkg::PROD_W-1:63] == {(cses_pkg::PROD_W-63){total[63]}});

    out_next.raw_bits = $signed(sum_raw);
    out_next.in_range = sum_inr;
    if (fits) begin
      out_next.physical_value = total[63:0];
    end else if (total[cses_pkg::PROD_W-1]) begin
      out_next.physical_value = $signed({1'b1, 63'd0});
    end else begin
      out_next.physical_value = $signed({1'b0, {63{1'b1}}});
    end
  end

  assign en_o     = !out_valid || !out_stall;
  assign en_s     = !sum_valid || en_o;
  assign en_m     = !mul_valid || en_s;
  assign in_stall = !en_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_m) begin
        mul_valid <= in_valid;
      end
      if (en_s) begin
        sum_valid <= mul_valid;
      end
      if (en_o) begin
        out_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_m) begin
      pp_lo   <= pp_lo_next;
      pp_hi   <= pp_hi_next;
      mul_raw <= in_data.raw;
      mul_inr <= in_data.in_range;
    end
    if (en_s) begin
      prod    <= prod_next;
      sum_raw <= mul_raw;
      sum_inr <= mul_inr;
    end
    if (en_o) begin
      out_data <= out_next;
    end
  end

`ifndef SYNTHESIS
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (sum_valid && !en_o) |=> sum_valid)
    else $error("sum stage dropped an item while the output stalled");

  a_sum_to_out: assert property (@(posedge clk) disable iff (rst)
    (sum_valid && en_o) |=> out_valid)
    else $error("sum stage advanced without filling the output register");
`endif

endmodule

`default_nettype wire

// ===== src/can_signal_extract_scale_top.sv =====
// CAN signal decoder: extracts one DBC signal from a classic CAN payload and
// scales it to a signed Q48.16 physical value with saturation.
// Input channel: in_valid / in_stall / in_data (payload, payload_length).
// A transfer happens at a rising edge with valid high and stall low.
// Output channel: out_valid / out_stall / out_data (raw_bits,
// physical_value, in_range), same transfer rule.
// Configuration: cfg_wr_en, cfg_index, cfg_wr_data write one register per
// cycle (start bit, bit length, byte order, signedness, factor, offset);
// write only while no item is in flight.
// Pipeline: the input transfer edge loads the extract register; the item then
// moves through the partial-product, product-sum and output registers, where
// out_valid rises. Throughput: one item per cycle while out_stall stays low.
// The two 33x32 partial products in the multiply stage set the cycle.
// When out_stall is high, the held result stays put and the earlier stages
// keep filling; in_stall rises once all four stages are occupied.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults: start bit 0, length 8, Intel order, unsigned, factor 1.0,
// offset 0.
`timescale 1ns / 1ps
`default_nettype none

module can_signal_extract_scale_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [cses_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cses_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cses_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cses_pkg::out_t                   out_data
);

  cses_pkg::cfg_t  cfg;
  cses_pkg::ext_t  ext_data;
  logic            ext_valid;
  logic            ext_stall;

  cses_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  cses_extract u_extract (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .ext_valid (ext_valid),
    .ext_stall (ext_stall),
    .ext_data  (ext_data)
  );

  cses_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (ext_valid),
    .in_stall  (ext_stall),
    .in_data   (ext_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_out_of_range_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.in_range) |->
      (out_data.raw_bits == 64'sd0 &&
       out_data.physical_value == 64'(cfg.scale_offset)))
    else $error("out-of-range result is not raw zero with the bare offset");
`endif

endmodule

`default_nettype wire

// ===== dv/can_signal_decode_checker.sv =====
`timescale 1ns / 1ps

module can_signal_decode_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [cses_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cses_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  cses_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  cses_pkg::out_t                  out_data,
  output int                              mismatch_count,
  output int                              pending_count,
  output int                              checked_count
);
  import cses_pkg::*;

  localparam logic signed [127:0] PHYS_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] PHYS_MIN = -PHYS_MAX - 128'sd1;

  cfg_t settings;
  out_t pending_decodes[$];
  out_t want;
  int   failures;
  int   checked;

  function automatic logic [63:0] low_mask(int n);
    return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic out_t decode_frame(cfg_t s, in_t frame);
    int width, avail, msb, lsb, top_byte, low_byte, hi_b, lo_b, nb, pos, remaining;
    logic [63:0] raw;
    logic [7:0] cur;
    logic neg;
    logic signed [127:0] wide_raw, factor_w, offset_w, total;
    out_t res;
    width = int'(s.bit_length);
    if (width == 0) width = 1;
    if (width > 64) width = 64;
    avail = int'(frame.payload_length);
    if (avail > PAYLOAD_BYTES) avail = PAYLOAD_BYTES;
    if (s.little_endian) begin
      lsb = int'(s.sig_start);
      msb = int'(s.sig_start) + width - 1;
    end else begin
      msb = int'(s.sig_start);
      lsb = ((int'(s.sig_start) ^ 7) + width - 1) ^ 7;
    end
    top_byte = msb >> 3;
    low_byte = lsb >> 3;
    raw = '0;
    neg = 1'b0;
    res.in_range = 1'b0;
    if (top_byte < avail) begin
      res.in_range = 1'b1;
      if (top_byte == low_byte) begin
        raw = (64'(frame.payload[8*top_byte +: 8]) >> (lsb % 8)) & low_mask(width);
      end else begin
        remaining = width;
        pos = top_byte;
        while (pos >= 0 && pos < avail && remaining > 0) begin
          hi_b = (pos == top_byte) ? msb % 8 : 7;
          lo_b = (pos == low_byte) ? lsb % 8 : 0;
          nb = hi_b - lo_b + 1;
          cur = frame.payload[8*pos +: 8];
          raw = (raw << nb) | (64'(cur >> lo_b) & low_mask(nb));
          remaining -= nb;
          pos += s.little_endian ? -1 : 1;
        end
      end
    end
    if (s.signed_en && raw[width-1]) begin
      raw |= ~low_mask(width);
      neg = 1'b1;
    end
    wide_raw = {{64{neg}}, raw};
    factor_w = {{96{s.scale_factor[31]}}, s.scale_factor};
    offset_w = {{80{s.scale_offset[47]}}, s.scale_offset};
    total = wide_raw * factor_w + offset_w;
    if (total > PHYS_MAX) total = PHYS_MAX;
    else if (total < PHYS_MIN) total = PHYS_MIN;
    res.raw_bits = raw;
    res.physical_value = total[63:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pending_decodes.delete();
      settings.sig_start     = 6'd0;
      settings.bit_length    = 7'd8;
      settings.little_endian = 1'b1;
      settings.signed_en     = 1'b0;
      settings.scale_factor  = 32'sd65536;
      settings.scale_offset  = 48'sd0;
      failures = 0;
      checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_decodes.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t unexpected result raw %h phys %h in_range %b", $realtime,
                     out_data.raw_bits, out_data.physical_value, out_data.in_range);
        end else begin
          want = pending_decodes.pop_front();
          checked++;
          if (out_data.raw_bits !== want.raw_bits ||
              out_data.physical_value !== want.physical_value ||
              out_data.in_range !== want.in_range) begin
            failures++;
            if (failures <= 10)
              $display("%0t mismatch raw %h/%h phys %h/%h in_range %b/%b (exp/got)",
                       $realtime, want.raw_bits, out_data.raw_bits,
                       want.physical_value, out_data.physical_value,
                       want.in_range, out_data.in_range);
          end
        end
      end
      if (in_valid && !in_stall)
        pending_decodes.push_back(decode_frame(settings, in_data));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SIG_START:     settings.sig_start     = cfg_wr_data[5:0];
          REG_BIT_LENGTH:    settings.bit_length    = cfg_wr_data[6:0];
          REG_LITTLE_ENDIAN: settings.little_endian = cfg_wr_data[0];
          REG_SIGNED_EN:     settings.signed_en     = cfg_wr_data[0];
          REG_SCALE_FACTOR:  settings.scale_factor  = cfg_wr_data[31:0];
          REG_SCALE_OFFSET:  settings.scale_offset  = cfg_wr_data[47:0];
          default: ;
        endcase
      end
    end
    mismatch_count <= failures;
    pending_count  <= pending_decodes.size();
    checked_count  <= checked;
  end

endmodule

// ===== dv/can_signal_extract_scale_top_tb.sv =====
`timescale 1ns / 1ps

module can_signal_extract_scale_top_tb;
  import cses_pkg::*;

  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_B = 3'd7;
  localparam logic signed [31:0] FACTOR_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FACTOR_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] OFFSET_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] OFFSET_MIN = 48'sh8000_0000_0000;
  localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIGN_ONLY = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PATTERN   = 64'h0123_4567_89AB_CDEF;
  localparam int RANDOM_PHASES = 14;
  localparam int FRAMES_PER_PHASE = 120;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  calm = 1'b0;
  int                    mismatch_count, pending_count, checked_count;
  int                    frames_sent = 0;
  int                    settings_count = 0;

  always #5 clk = ~clk;

  can_signal_extract_scale_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  can_signal_decode_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  task automatic send_frame(logic [63:0] payload, logic [3:0] byte_count);
    if (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 31);
    end
    in_valid <= 1'b1;
    in_data  <= '{payload: payload, payload_length: byte_count};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
  endtask

  task automatic program_settings(int sb, int len, bit le, bit sgn,
                                  logic signed [31:0] factor, logic signed [47:0] offset);
    settle();
    write_reg(REG_SIG_START, 48'(sb));
    write_reg(REG_BIT_LENGTH, 48'(len));
    write_reg(REG_LITTLE_ENDIAN, 48'(le));
    write_reg(REG_SIGNED_EN, 48'(sgn));
    write_reg(REG_SCALE_FACTOR, 48'(factor));
    write_reg(REG_SCALE_OFFSET, offset);
    // unused index: must leave every register untouched
    write_reg($urandom_range(1, 0) ? SPARE_IDX_A : SPARE_IDX_B, 48'({$urandom, $urandom}));
    cfg_wr_en <= 1'b0;
    settings_count++;
  endtask

  initial begin
    int pick, len, eff, pos, sb;
    bit le, sgn;
    logic signed [31:0] factor;
    logic signed [47:0] offset;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(64'h0, 4'd0);
    send_frame(ALL_ONES, 4'd8);
    send_frame(PATTERN, 4'd15);
    send_frame(PATTERN, 4'd9);
    program_settings(0, 64, 1, 0, FACTOR_MAX, OFFSET_MAX);
    send_frame(ALL_ONES, 4'd8);
    send_frame(PATTERN, 4'd8);
    program_settings(0, 64, 1, 1, FACTOR_MIN, OFFSET_MIN);
    send_frame(SIGN_ONLY, 4'd8);
    send_frame(ALL_ONES, 4'd8);
    program_settings(7, 64, 0, 1, 32'sh0001_8000, 48'sh0000_0001_0000);
    send_frame(PATTERN, 4'd8);
    send_frame(PATTERN, 4'd4);
    send_frame(PATTERN, 4'd0);
    program_settings(63, 0, 1, 1, 32'sh0000_4000, -48'sh123);
    send_frame(ALL_ONES, 4'd8);
    send_frame(ALL_ONES, 4'd7);
    program_settings(10, 127, 1, 0, FACTOR_MAX, 48'sh0);
    send_frame(ALL_ONES, 4'd8);
    program_settings(0, 12, 0, 1, -32'sh0001_0000, 48'sh0);
    send_frame(PATTERN, 4'd8);
    send_frame(PATTERN, 4'd1);
    program_settings(60, 20, 0, 1, 32'sh0002_0000, OFFSET_MAX);
    send_frame(ALL_ONES, 4'd8);
    send_frame(PATTERN, 4'd8);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      calm <= (phase == 6 || phase == 7);
      if (phase == 0) begin
        program_settings(0, 1, 1, 0, FACTOR_MIN, OFFSET_MAX);
      end else if (phase == 1) begin
        program_settings(63, 64, 0, 1, FACTOR_MAX, OFFSET_MIN);
      end else begin
        pick = $urandom_range(99);
        len = (pick < 6) ? 0 : (pick < 12) ? $urandom_range(127, 65) :
              (pick < 35) ? $urandom_range(8, 1) : $urandom_range(64, 1);
        eff = (len == 0) ? 1 : (len > 64) ? 64 : len;
        le = 1'($urandom_range(1, 0));
        sgn = 1'($urandom_range(1, 0));
        // keep the signal inside the frame most of the time
        pos = ($urandom_range(99) < 85) ? $urandom_range(64 - eff, 0) : $urandom_range(63, 0);
        sb = le ? pos : (pos ^ 7);
        case ($urandom_range(3, 0))
          0: begin
            factor = $urandom_range(262144, 0);
            if ($urandom_range(1, 0)) factor = -factor;
          end
          1: factor = $urandom_range(1, 0) ? FACTOR_MIN : FACTOR_MAX;
          default: factor = $urandom;
        endcase
        case ($urandom_range(2, 0))
          0: begin
            offset = 48'($urandom_range(1048576, 0));
            if ($urandom_range(1, 0)) offset = -offset;
          end
          1: offset = $urandom_range(1, 0) ? OFFSET_MIN : OFFSET_MAX;
          default: offset = 48'({$urandom, $urandom});
        endcase
        program_settings(sb, len, le, sgn, factor, offset);
      end
      repeat (FRAMES_PER_PHASE)
        send_frame({$urandom, $urandom},
                   ($urandom_range(99) < 75) ? 4'd8 : 4'($urandom_range(15, 0)));
    end

    settle();
    repeat (8) @(posedge clk);
    $display("decoded %0d frames under %0d register settings, both byte orders and signedness",
             frames_sent, settings_count);
    $display("compared %0d results, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[can_signal_extract_scale_top] OK");
    end else begin
      $display("[can_signal_extract_scale_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", pending_count);
    $display("[can_signal_extract_scale_top] ERROR");
    $finish;
  end

endmodule
